// ----- rtl/core/plist_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_pkg
// Shared widths, word types, request kinds and status codes of the
// positional list store.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int KIND_W = 2;
    localparam int POS_W  = 9;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 9;
    localparam int STAT_W = 2;

    localparam int DEF_CAPACITY = 256;

    typedef logic [KIND_W-1:0]        kind_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [LEN_W-1:0]         len_t;
    typedef logic [STAT_W-1:0]        status_t;

    // request kinds
    localparam kind_t K_READ   = 2'd0;
    localparam kind_t K_WRITE  = 2'd1;
    localparam kind_t K_INSERT = 2'd2;
    localparam kind_t K_REMOVE = 2'd3;

    // result status codes
    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_EMPTY  = 2'd1;
    localparam status_t ST_BADPOS = 2'd2;
    localparam status_t ST_FULL   = 2'd3;

endpackage

// ----- rtl/core/plist_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_mem
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module plist_mem #(
    parameter int DEPTH = plist_pkg::DEF_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  plist_pkg::word_t    wdata,
    input  logic [AW-1:0]       raddr,
    output plist_pkg::word_t    rdata
);
    import plist_pkg::*;

    word_t mem [DEPTH];
    word_t rdata_reg;

    // write the entry and register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/plist_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_ctrl
// Request sequencer: checks each request against the entry count, runs
// the shift passes over the memory and drives the result word.
// ----------------------------------------------------------------------------
module plist_ctrl #(
    parameter int CAPACITY = plist_pkg::DEF_CAPACITY,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  plist_pkg::kind_t     kind,
    input  plist_pkg::pos_t      position,
    input  plist_pkg::word_t     value,
    output logic                 done,
    output plist_pkg::status_t   status,
    output plist_pkg::word_t     data,
    output plist_pkg::len_t      length,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output plist_pkg::word_t     mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  plist_pkg::word_t     mem_rdata
);
    import plist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_UP    = 3'd2;
    localparam logic [2:0] S_DN    = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    kind_t         kind_reg, kind_next;
    logic [AW-1:0] p0_reg, p0_next;
    word_t         val_reg, val_next;
    logic [AW-1:0] src_reg, src_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    word_t         data_reg, data_next;
    len_t          length_reg, length_next;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [AW-1:0] p_in;
    logic [AW-1:0] last_idx;
    logic          full;

    // widen position and count to a common compare width
    assign pos_x    = XW'(position);
    assign cnt_x    = XW'(cnt_reg);
    assign p_in     = AW'(pos_x - XW'(1));
    assign last_idx = AW'(cnt_reg - CW'(1));
    assign full     = (cnt_reg == CW'(CAPACITY));

    // sequence requests and shift passes
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        p0_next     = p0_reg;
        val_next    = val_reg;
        src_next    = src_reg;
        pend_next   = 1'b0;
        wptr_next   = wptr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        length_next = length_reg;

        // a pending shift write takes the port; otherwise direct writes
        mem_we    = pend_reg;
        mem_waddr = wptr_reg;
        mem_wdata = mem_rdata;
        mem_raddr = src_reg;

        case (state_reg)
            S_IDLE:
            begin
                mem_raddr = p_in;
                if (start)
                begin
                    kind_next   = kind;
                    p0_next     = p_in;
                    val_next    = value;
                    status_next = ST_OK;
                    data_next   = '0;
                    length_next = LEN_W'(cnt_reg);
                    if (kind == K_INSERT)
                    begin
                        if (position == '0 || pos_x > cnt_x + XW'(1))
                        begin
                            status_next = ST_BADPOS;
                            done_next   = 1'b1;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                            done_next   = 1'b1;
                        end
                        else if (pos_x == cnt_x + XW'(1))
                        begin
                            // append: no entries to move
                            mem_we      = 1'b1;
                            mem_waddr   = p_in;
                            mem_wdata   = value;
                            cnt_next    = cnt_reg + CW'(1);
                            length_next = LEN_W'(cnt_reg + CW'(1));
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            src_next   = last_idx;
                            state_next = S_UP;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        done_next   = 1'b1;
                    end
                    else if (position == '0 || pos_x > cnt_x)
                    begin
                        status_next = ST_BADPOS;
                        done_next   = 1'b1;
                    end
                    else if (kind == K_WRITE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = p_in;
                        mem_wdata = value;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                // addressed word is on the read port now
                data_next = mem_rdata;
                if (kind_reg == K_READ || p0_reg == last_idx)
                begin
                    if (kind_reg == K_REMOVE)
                    begin
                        cnt_next    = cnt_reg - CW'(1);
                        length_next = LEN_W'(cnt_reg - CW'(1));
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    src_next   = p0_reg + AW'(1);
                    state_next = S_DN;
                end
            end

            S_UP:
            begin
                // read src, write it one place higher next cycle
                mem_raddr = src_reg;
                pend_next = 1'b1;
                wptr_next = src_reg + AW'(1);
                if (src_reg == p0_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    src_next = src_reg - AW'(1);
                end
            end

            S_DN:
            begin
                // read src, write it one place lower next cycle
                mem_raddr = src_reg;
                pend_next = 1'b1;
                wptr_next = src_reg - AW'(1);
                if (src_reg == last_idx)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    src_next = src_reg + AW'(1);
                end
            end

            S_FLUSH:
            begin
                // last shifted word is written this cycle
                if (kind_reg == K_INSERT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cnt_next    = cnt_reg - CW'(1);
                    length_next = LEN_W'(cnt_reg - CW'(1));
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_PUT:
            begin
                mem_we      = 1'b1;
                mem_waddr   = p0_reg;
                mem_wdata   = val_reg;
                cnt_next    = cnt_reg + CW'(1);
                length_next = LEN_W'(cnt_reg + CW'(1));
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // hold request and result payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        p0_reg     <= p0_next;
        val_reg    <= val_next;
        src_reg    <= src_next;
        wptr_reg   <= wptr_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        length_reg <= length_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign length = length_reg;

endmodule

// ----- rtl/core/positional_list_store_top.sv -----
`timescale 1ns / 1ps
// Errors, overwrites and appends report done straight from idle; a read or a
// tail remove passes through fetch; an insert or remove that moves entries
// runs a shift pass, one entry moved per cycle through the single write port
// of the entry memory, then flush (and put for an insert). One request at a time.
// Reset clears the entry count and sequencer state; entry memory is not cleared.
// The result word shows for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// positional_list_store_top
// Bounded ordered list of signed words addressed by 1-based position.
// ----------------------------------------------------------------------------
module positional_list_store_top #(
    parameter int CAPACITY = plist_pkg::DEF_CAPACITY
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  plist_pkg::kind_t     kind,
    input  plist_pkg::pos_t      position,
    input  plist_pkg::word_t     value,
    output logic                 done,
    output plist_pkg::status_t   status,
    output plist_pkg::word_t     data,
    output plist_pkg::len_t      length
);
    import plist_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    word_t         mem_wdata;
    logic [AW-1:0] mem_raddr;
    word_t         mem_rdata;

    // sequencer
    plist_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .position  (position),
        .value     (value),
        .done      (done),
        .status    (status),
        .data      (data),
        .length    (length),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // entry storage
    plist_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the positional list store and checks every result
// word against a behavioral list kept inside the bench. A directed opening
// covers the empty, head, middle, tail and out-of-range cases. Random traffic
// then fills the store to capacity, presses on the full store and drains it
// again, with random idle bursts on the request side.
// ----------------------------------------------------------------------------
module testbench;

    import plist_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int ITEM_CAP    = 1000;
    localparam int CYCLE_LIMIT = ITEM_CAP * (CAPACITY + 12) * 3;

    typedef struct {
        kind_t       kind;
        pos_t        pos;
        word_t       val;
        int unsigned idle;
    } request_t;

    typedef struct {
        status_t status;
        word_t   data;
        len_t    length;
    } reply_t;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    logic    start    = 1'b0;
    kind_t   kind     = K_READ;
    pos_t    position = '0;
    word_t   value    = '0;
    logic    busy;
    logic    done;
    status_t status;
    word_t   data;
    len_t    length;

    // requests waiting to be driven, replies waiting to arrive
    request_t pending_requests[$];
    reply_t   awaited_replies[$];

    // list contents as the block should hold them
    word_t list_mem [CAPACITY];
    int    list_len = 0;

    // list length as the stimulus generator sees it
    int gen_len = 0;

    int          words_sent  = 0;
    int          words_taken = 0;
    int unsigned idle_left   = 0;
    int          fail_count  = 0;
    request_t    next_req;
    reply_t      got_reply;
    reply_t      want_reply;

    positional_list_store_top #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .position (position),
        .value    (value),
        .done     (done),
        .status   (status),
        .data     (data),
        .length   (length)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // apply one request to the list and return the reply it should produce
    function automatic reply_t apply_request(kind_t k, pos_t p_in, word_t v);
        reply_t r;
        int     p;
        int     i;
        p = p_in;
        r.status = ST_OK;
        r.data   = '0;
        if (k == K_INSERT)
        begin
            if (p < 1 || p > list_len + 1)
                r.status = ST_BADPOS;
            else if (list_len >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                for (i = list_len; i > p - 1; i--)
                    list_mem[i] = list_mem[i-1];
                list_mem[p-1] = v;
                list_len++;
            end
        end
        else if (list_len == 0)
            r.status = ST_EMPTY;
        else if (p < 1 || p > list_len)
            r.status = ST_BADPOS;
        else if (k == K_READ)
            r.data = list_mem[p-1];
        else if (k == K_WRITE)
            list_mem[p-1] = v;
        else
        begin
            r.data = list_mem[p-1];
            for (i = p - 1; i + 1 < list_len; i++)
                list_mem[i] = list_mem[i+1];
            list_len--;
        end
        r.length = len_t'(list_len);
        return r;
    endfunction

    // queue one request and track the length it leaves behind
    task automatic queue_request(kind_t k, int p, word_t v, int unsigned idle);
        request_t req;
        req.kind = k;
        req.pos  = pos_t'(p);
        req.val  = v;
        req.idle = idle;
        pending_requests.push_back(req);
        if (k == K_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < CAPACITY)
            gen_len++;
        else if (k == K_REMOVE && gen_len > 0 && p >= 1 && p <= gen_len)
            gen_len--;
    endtask

    function automatic int unsigned pick_idle();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // favor head, tail and valid positions; leave some out of range
    function automatic int pick_pos(kind_t k);
        int top;
        int r;
        top = (k == K_INSERT) ? gen_len + 1 : gen_len;
        r   = $urandom_range(0, 99);
        if (top == 0 || r < 4)
            return $urandom_range(0, 511);
        else if (r < 8)
            return (r < 6) ? 0 : top + 1;
        else if (r < 20)
            return 1;
        else if (r < 32)
            return top;
        else
            return $urandom_range(1, top);
    endfunction

    task automatic queue_random(int ins_w, int rem_w);
        kind_t k;
        int    r;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            k = K_INSERT;
        else if (r < ins_w + rem_w)
            k = K_REMOVE;
        else
            k = $urandom_range(0, 1) ? K_READ : K_WRITE;
        queue_request(k, pick_pos(k), pick_word(), pick_idle());
    endtask

    // build stimulus, run reset, then wait for the last reply
    initial
    begin
        int first_quiet;

        // empty list and out-of-range cases
        queue_request(K_READ,   1,   32'h1234_5678, pick_idle());
        queue_request(K_WRITE,  1,   32'h1234_5678, pick_idle());
        queue_request(K_REMOVE, 511, '0,            pick_idle());
        queue_request(K_INSERT, 0,   32'h0F0F_0F0F, pick_idle());
        queue_request(K_INSERT, 2,   32'h0F0F_0F0F, pick_idle());
        // first entry, head insert, append, middle insert
        queue_request(K_INSERT, 1,   32'h7FFF_FFFF, pick_idle());
        queue_request(K_INSERT, 1,   32'h8000_0000, pick_idle());
        queue_request(K_INSERT, 3,   '1,            pick_idle());
        queue_request(K_INSERT, 2,   '0,            pick_idle());
        queue_request(K_INSERT, 6,   32'h0F0F_0F0F, pick_idle());
        queue_request(K_READ,   1,   '0,            pick_idle());
        queue_request(K_READ,   2,   '0,            pick_idle());
        queue_request(K_READ,   3,   '0,            pick_idle());
        queue_request(K_READ,   4,   '0,            pick_idle());
        queue_request(K_READ,   0,   '0,            pick_idle());
        queue_request(K_READ,   5,   '0,            pick_idle());
        queue_request(K_WRITE,  511, 32'hFFFF_0000, pick_idle());
        queue_request(K_WRITE,  2,   32'h5A5A_5A5A, pick_idle());
        // middle, head and tail removes
        queue_request(K_REMOVE, 2,   32'hA5A5_A5A5, pick_idle());
        queue_request(K_REMOVE, 1,   '0,            pick_idle());
        queue_request(K_REMOVE, 2,   '0,            pick_idle());
        queue_request(K_REMOVE, 0,   '0,            pick_idle());
        queue_request(K_READ,   1,   '0,            pick_idle());
        queue_request(K_INSERT, 256, 32'h0F0F_0F0F, pick_idle());

        // fill to capacity, dwell at full, drain, then a short mix
        while (gen_len < CAPACITY && pending_requests.size() < ITEM_CAP - 200)
            queue_random(80, 5);
        repeat (20)
            queue_random(40, 20);
        while (gen_len > 0 && pending_requests.size() < ITEM_CAP - 30)
            queue_random(5, 80);
        repeat (30)
            queue_random(40, 35);

        // no idling over the tail of the run
        first_quiet = pending_requests.size() - 100;
        for (int i = first_quiet; i < pending_requests.size(); i++)
            pending_requests[i].idle = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || words_taken != words_sent ||
               awaited_replies.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // drive the next word at the falling edge once the last one is taken
    always @(negedge clk)
    begin
        if (rst_n && !(start && words_taken != words_sent))
        begin
            if (idle_left > 0)
            begin
                start     <= 1'b0;
                idle_left = idle_left - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req   = pending_requests.pop_front();
                kind       <= next_req.kind;
                position   <= next_req.pos;
                value      <= next_req.val;
                start      <= 1'b1;
                words_sent = words_sent + 1;
                idle_left  = next_req.idle;
            end
            else
                start <= 1'b0;
        end
    end

    // check replies and record accepted requests at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            got_reply.status = status;
            got_reply.data   = data;
            got_reply.length = length;
            if (awaited_replies.size() == 0)
            begin
                $error("reply word with no request outstanding");
                fail_count++;
            end
            else
            begin
                want_reply = awaited_replies.pop_front();
                if (got_reply.status !== want_reply.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want_reply.status, got_reply.status);
                    fail_count++;
                end
                if (got_reply.data !== want_reply.data)
                begin
                    $error("data mismatch: expected %0d, actual %0d",
                           want_reply.data, got_reply.data);
                    fail_count++;
                end
                if (got_reply.length !== want_reply.length)
                begin
                    $error("length mismatch: expected %0d, actual %0d",
                           want_reply.length, got_reply.length);
                    fail_count++;
                end
            end
        end
        if (rst_n && start && busy === 1'b0)
        begin
            awaited_replies.push_back(apply_request(kind, position, value));
            words_taken++;
        end
    end

    // stop a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
